// File: rtl/core/kmp_stream_matcher_assert.svh
// Assertion macros for the streaming KMP matcher.
// Used by kmp_stream_matcher; expects clk and rst_n in the including scope.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define KMP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmp_stream_matcher: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define KMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmp_stream_matcher: next-cycle check failed");

`endif

// File: rtl/core/kmp_pkg.sv
// Shared constants, register codes and the pattern byte selector of the KMP matcher.
// No dependencies.
package kmp_pkg;

    // Register file layout
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_CFG_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    // Input word actions
    localparam logic ACTION_TEXT = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    // Pattern storage: sixteen bytes held in two 64-bit registers
    localparam int BYTE_W       = 8;
    localparam int PAT_BYTES    = 16;
    localparam int PAT_IDX_W    = 4;
    localparam int PAT_VEC_W    = PAT_BYTES * BYTE_W;
    localparam int IDX_W        = 7;

    // Selects pattern byte idx; bytes beyond the stored sixteen read as zero.
    function automatic logic [BYTE_W-1:0] pat_byte(
        input logic [PAT_VEC_W-1:0] bytes,
        input logic [IDX_W-1:0]     idx
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (idx < IDX_W'(PAT_BYTES))
        begin
            b = bytes[idx[PAT_IDX_W-1:0] * BYTE_W +: BYTE_W];
        end
        return b;
    endfunction

endpackage

// File: rtl/core/kmp_stream_matcher.sv
// Streaming Knuth-Morris-Pratt matcher: configuration registers, failure table
// memory and the sequencer that builds the table and walks the failure chain.
// Depends on kmp_pkg and kmp_stream_matcher_assert.svh.
//
//  Channel | Direction | Handshake             | Word
//  --------+-----------+-----------------------+----------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid  / in_ready  | action, text_byte
//  out     | out       | out_valid / out_ready | match_found, start_position
//
// A text byte passes through S_WALK, S_WALK_CHAIN once per failure-link step and
// S_FALL when a full match falls back through its link; the shared byte comparator
// and the single read port of the failure table set this. A new word is taken only
// once the last one is done; end of text and an empty pattern finish in S_WALK. A
// register write rebuilds the table through S_BUILD_START, then S_BUILD for each
// later pattern byte and S_BUILD_CHAIN for each link step, during which no word is
// accepted. Reset is asynchronous and clears all control state; the table needs
// no clearing. A finished result waits in a holding stage, so a stalled output
// stops new words only when both the holding stage and the output are full.
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX    = 16,
    parameter int POSITION_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [7:0]             text_byte,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   match_found,
    output logic [31:0]            start_position
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int ADDR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int POS_W  = POSITION_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD_START,
        S_BUILD,
        S_BUILD_CHAIN,
        S_WALK,
        S_WALK_CHAIN,
        S_FALL
    } state_t;

    // Registers
    state_t                 state_reg, state_next;
    logic [LEN_CFG_W-1:0]   pattern_length_reg, pattern_length_next;
    logic [CFG_DATA_W-1:0]  pattern_low_reg, pattern_low_next;
    logic [CFG_DATA_W-1:0]  pattern_high_reg, pattern_high_next;
    logic [LEN_W-1:0]       ml_reg, ml_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [LEN_W-1:0]       k_reg, k_next;
    logic [ADDR_W-1:0]      i_reg, i_next;
    logic                   action_reg, action_next;
    logic [BYTE_W-1:0]      text_byte_reg, text_byte_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_found_reg, pend_found_next;
    logic [POS_W-1:0]       pend_pos_reg, pend_pos_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   match_found_reg, match_found_next;
    logic [31:0]            start_position_reg, start_position_next;
    logic [LEN_W-1:0]       rd_data_reg;

    // Failure table memory and its port controls
    logic [LEN_W-1:0]       fail_mem [PATTERN_MAX];
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [LEN_W-1:0]       mem_wdata;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    // Shared compare unit and its operands
    logic [PAT_VEC_W-1:0]   pattern_vec;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       eff_last;
    logic                   chain_state;
    logic                   build_state;
    logic [LEN_W-1:0]       k_cur;
    logic [LEN_W-1:0]       k_inc;
    logic [LEN_W-1:0]       k_dec;
    logic [BYTE_W-1:0]      cmp_a;
    logic                   eq;

    assign pattern_vec = {pattern_high_reg, pattern_low_reg};

    // Effective length saturates at the pattern capacity.
    always_comb
    begin
        if (int'(pattern_length_reg) > PATTERN_MAX)
        begin
            eff_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            eff_len = LEN_W'(pattern_length_reg);
        end
    end

    assign eff_last = eff_len - LEN_W'(1);

    // In a chain state the candidate length comes straight from the table read.
    assign chain_state = (state_reg == S_BUILD_CHAIN) || (state_reg == S_WALK_CHAIN);
    assign build_state = (state_reg == S_BUILD) || (state_reg == S_BUILD_CHAIN);
    assign k_cur       = chain_state ? rd_data_reg : k_reg;
    assign k_inc       = k_cur + LEN_W'(eq);
    assign k_dec       = k_cur - LEN_W'(1);
    assign cmp_a       = build_state ? pat_byte(pattern_vec, IDX_W'(i_reg)) : text_byte_reg;
    assign eq          = (cmp_a == pat_byte(pattern_vec, IDX_W'(k_cur)));

    // Handshakes: a new word may enter while the holding word moves on.
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid &&
                       (!pend_valid_reg || !out_valid_reg || out_ready);

    assign out_valid      = out_valid_reg;
    assign match_found    = match_found_reg;
    assign start_position = start_position_reg;

    // Next-state logic for the sequencer, registers and output stages.
    always_comb
    begin
        state_next          = state_reg;
        pattern_length_next = pattern_length_reg;
        pattern_low_next    = pattern_low_reg;
        pattern_high_next   = pattern_high_reg;
        ml_next             = ml_reg;
        pos_next            = pos_reg;
        k_next              = k_reg;
        i_next              = i_reg;
        action_next         = action_reg;
        text_byte_next      = text_byte_reg;
        pend_valid_next     = pend_valid_reg;
        pend_found_next     = pend_found_reg;
        pend_pos_next       = pend_pos_reg;
        out_valid_next      = out_valid_reg;
        match_found_next    = match_found_reg;
        start_position_next = start_position_reg;
        mem_we              = 1'b0;
        mem_waddr           = i_reg;
        mem_wdata           = k_inc;
        rd_en               = 1'b0;
        rd_addr             = k_dec[ADDR_W-1:0];

        // Output stage: the holding word moves on when the output is free.
        if (pend_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next      = 1'b1;
            match_found_next    = pend_found_reg;
            start_position_next = 32'(pend_pos_reg);
            pend_valid_next     = 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (cfg_index)
                        REG_PATTERN_LENGTH:
                        begin
                            pattern_length_next = cfg_data[LEN_CFG_W-1:0];
                            ml_next             = '0;
                            state_next          = S_BUILD_START;
                        end
                        REG_PATTERN_LOW:
                        begin
                            pattern_low_next = cfg_data;
                            ml_next          = '0;
                            state_next       = S_BUILD_START;
                        end
                        REG_PATTERN_HIGH:
                        begin
                            pattern_high_next = cfg_data;
                            ml_next           = '0;
                            state_next        = S_BUILD_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (in_valid && in_ready)
                begin
                    action_next    = action;
                    text_byte_next = text_byte;
                    k_next         = (ml_reg >= eff_len) ? '0 : ml_reg;
                    state_next     = S_WALK;
                end
            end

            // Entry zero of the table is always zero.
            S_BUILD_START:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '0;
                k_next     = '0;
                i_next     = ADDR_W'(1);
                state_next = (eff_len > LEN_W'(1)) ? S_BUILD : S_IDLE;
            end

            // One prefix-function step per cycle; a mismatch follows a link.
            S_BUILD, S_BUILD_CHAIN:
            begin
                if ((k_cur != '0) && !eq)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_dec[ADDR_W-1:0];
                    state_next = S_BUILD_CHAIN;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = i_reg;
                    mem_wdata = k_inc;
                    k_next    = k_inc;
                    if (LEN_W'(i_reg) == eff_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + ADDR_W'(1);
                        state_next = S_BUILD;
                    end
                end
            end

            // Text walk: end of text and the empty pattern finish at once.
            S_WALK, S_WALK_CHAIN:
            begin
                if ((state_reg == S_WALK) && (action_reg == ACTION_END))
                begin
                    pend_valid_next = 1'b1;
                    pend_found_next = (eff_len == '0);
                    pend_pos_next   = (eff_len == '0) ? pos_reg : '0;
                    pos_next        = '0;
                    ml_next         = '0;
                    state_next      = S_IDLE;
                end
                else if ((state_reg == S_WALK) && (eff_len == '0))
                begin
                    pend_valid_next = 1'b1;
                    pend_found_next = 1'b1;
                    pend_pos_next   = pos_reg;
                    pos_next        = pos_reg + POS_W'(1);
                    state_next      = S_IDLE;
                end
                else if ((k_cur != '0) && !eq)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_dec[ADDR_W-1:0];
                    state_next = S_WALK_CHAIN;
                end
                else if (k_inc == eff_len)
                begin
                    // Full match: fetch the link of the last pattern byte.
                    rd_en      = 1'b1;
                    rd_addr    = k_cur[ADDR_W-1:0];
                    state_next = S_FALL;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_found_next = 1'b0;
                    pend_pos_next   = '0;
                    ml_next         = k_inc;
                    pos_next        = pos_reg + POS_W'(1);
                    state_next      = S_IDLE;
                end
            end

            // Report the match and fall back so overlapping matches are seen.
            S_FALL:
            begin
                pend_valid_next = 1'b1;
                pend_found_next = 1'b1;
                pend_pos_next   = pos_reg - POS_W'(eff_last);
                ml_next         = rd_data_reg;
                pos_next        = pos_reg + POS_W'(1);
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            ml_reg             <= '0;
            pos_reg            <= '0;
            k_reg              <= '0;
            i_reg              <= '0;
            pend_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            pattern_length_reg <= pattern_length_next;
            pattern_low_reg    <= pattern_low_next;
            pattern_high_reg   <= pattern_high_next;
            ml_reg             <= ml_next;
            pos_reg            <= pos_next;
            k_reg              <= k_next;
            i_reg              <= i_next;
            pend_valid_reg     <= pend_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        action_reg         <= action_next;
        text_byte_reg      <= text_byte_next;
        pend_found_reg     <= pend_found_next;
        pend_pos_reg       <= pend_pos_next;
        match_found_reg    <= match_found_next;
        start_position_reg <= start_position_next;
    end

    // Failure table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fail_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= fail_mem[rd_addr];
        end
    end

`include "kmp_stream_matcher_assert.svh"

    // The matched length stays short of a full match between words.
    `KMP_ASSERT_IMPL(a_ml_below_len, (state_reg == S_IDLE) && (eff_len != '0), ml_reg < eff_len)
    // Each failure link points strictly below the length it was taken from.
    `KMP_ASSERT_IMPL(a_link_shrinks, chain_state, rd_data_reg < $past(k_cur))
    // The holding stage is empty whenever a text word is being worked on.
    `KMP_ASSERT_IMPL(a_pend_free, (state_reg == S_WALK) || (state_reg == S_WALK_CHAIN) || (state_reg == S_FALL), !pend_valid_reg)
    // A fall-back always leaves a found match in the holding stage.
    `KMP_ASSERT_NEXT(a_fall_reports, state_reg == S_FALL, pend_valid_reg && pend_found_reg)
    // A word without a match carries a zero start position.
    `KMP_ASSERT_IMPL(a_nomatch_zero, out_valid && !match_found, start_position == '0)

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for kmp_stream_matcher: drives pattern registers and text words,
// predicts every result word with its own KMP matcher and compares them in order.
// Depends on kmp_pkg and the kmp_stream_matcher RTL.
module testbench;
    import kmp_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 12;
    localparam int GAP_PERCENT = 23;
    localparam int SETTLE      = 4;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 100;
    localparam int CALM_FROM   = 450;
    localparam int CALM_TO     = 750;

    // Register index past the end of the register file; a write there is ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_word;
        logic                   act;
        logic [7:0]             byte_val;
    } stim_word_t;

    typedef struct packed {
        logic        found;
        logic [31:0] start;
    } match_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   action = ACTION_TEXT;
    logic [7:0]             text_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   match_found;
    logic [31:0]            start_position;

    stim_word_t stim_q[$];
    match_t     expected_matches[$];

    logic in_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int   quiet_cycles = 0;
    int   accepted_words = 0;
    int   cycle_count = 0;
    int   errors = 0;

    // Shadow copy of the pattern registers and of the matcher state.
    logic [LEN_CFG_W-1:0] len_reg = '0;
    logic [PAT_VEC_W-1:0] pat_vec_reg = '0;
    logic [7:0]           pat_mem [PAT_BYTES];
    int                   fail_link [PAT_BYTES];
    int                   pat_len;
    int                   run_len;
    logic [31:0]          text_pos = '0;

    kmp_stream_matcher u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .text_byte      (text_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .match_found    (match_found),
        .start_position (start_position)
    );

    always #CLK_HALF clk = ~clk;

    // Rebuilds the failure links from the shadow registers and drops any partial match.
    function automatic void rebuild_failure_links();
        int k;
        pat_len = (len_reg > PAT_BYTES) ? PAT_BYTES : int'(len_reg);
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pat_mem[i]   = pat_vec_reg[i*8 +: 8];
            fail_link[i] = 0;
        end
        for (int i = 1; i < pat_len; i++)
        begin
            k = fail_link[i-1];
            while (k > 0 && pat_mem[i] != pat_mem[k])
                k = fail_link[k-1];
            if (pat_mem[i] == pat_mem[k])
                k++;
            fail_link[i] = k;
        end
        run_len = 0;
    endfunction

    function automatic void load_pattern_reg(logic [CFG_INDEX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] data);
        if (idx == REG_PATTERN_LENGTH)
            len_reg = data[LEN_CFG_W-1:0];
        else if (idx == REG_PATTERN_LOW)
            pat_vec_reg[63:0] = data;
        else if (idx == REG_PATTERN_HIGH)
            pat_vec_reg[127:64] = data;
        else
            return;
        rebuild_failure_links();
    endfunction

    // Advances the matcher by one word and returns the result word it should give.
    function automatic match_t kmp_advance(logic act, logic [7:0] c);
        match_t r;
        int     k;
        r = '0;
        if (act == ACTION_END)
        begin
            if (pat_len == 0)
            begin
                r.found = 1'b1;
                r.start = text_pos;
            end
            text_pos = '0;
            run_len  = 0;
        end
        else
        begin
            if (pat_len == 0)
            begin
                r.found = 1'b1;
                r.start = text_pos;
            end
            else
            begin
                k = (run_len >= pat_len) ? 0 : run_len;
                while (k > 0 && c != pat_mem[k])
                    k = fail_link[k-1];
                if (c == pat_mem[k])
                    k++;
                if (k == pat_len)
                begin
                    r.found = 1'b1;
                    r.start = text_pos - 32'(pat_len) + 32'd1;
                    k = fail_link[k-1];
                end
                run_len = k;
            end
            text_pos = text_pos + 32'd1;
        end
        return r;
    endfunction

    // Random gaps on both sides, except over a calm stretch in the middle of the run.
    function automatic bit take_gap();
        if (accepted_words >= CALM_FROM && accepted_words < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < GAP_PERCENT;
    endfunction

    task automatic push_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_word_t w;
        w = '0;
        w.is_cfg   = 1'b1;
        w.cfg_idx  = idx;
        w.cfg_word = data;
        stim_q.insert(stim_q.size(), w);
    endtask

    task automatic push_word(logic act, logic [7:0] b);
        stim_word_t w;
        w = '0;
        w.act      = act;
        w.byte_val = b;
        stim_q.insert(stim_q.size(), w);
    endtask

    // Driver: text and register words change on the falling edge only, never together.
    always @(negedge clk)
    begin
        stim_word_t w;
        logic       nv;
        logic       in_raised;
        in_raised = 1'b0;
        if (rst_n)
        begin
            if (!(in_valid && !in_taken))
            begin
                nv = 1'b0;
                if (stim_q.size() != 0 && !stim_q[0].is_cfg && !cfg_valid && !take_gap())
                begin
                    w = stim_q.pop_front();
                    action    <= w.act;
                    text_byte <= w.byte_val;
                    nv = 1'b1;
                end
                in_valid <= nv;
                in_raised = nv;
            end
            if (!(cfg_valid && !cfg_taken))
            begin
                nv = 1'b0;
                if (stim_q.size() != 0 && stim_q[0].is_cfg && !in_valid && !in_raised
                    && expected_matches.size() == 0 && quiet_cycles >= SETTLE)
                begin
                    w = stim_q.pop_front();
                    cfg_index <= w.cfg_idx;
                    cfg_data  <= w.cfg_word;
                    nv = 1'b1;
                end
                cfg_valid <= nv;
            end
        end
        out_ready <= !take_gap();
    end

    // Monitor: samples every handshake on the rising edge and checks result words.
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                load_pattern_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                expected_matches.insert(expected_matches.size(),
                                        kmp_advance(action, text_byte));
                accepted_words++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    $display("%0t: unexpected result word, match_found %0b start_position %0d",
                             $time, match_found, start_position);
                    errors++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (match_found !== want.found)
                    begin
                        $display("%0t: match_found expected %0b, got %0b",
                                 $time, want.found, match_found);
                        errors++;
                    end
                    if (start_position !== want.start)
                    begin
                        $display("%0t: start_position expected %0d, got %0d",
                                 $time, want.start, start_position);
                        errors++;
                    end
                end
            end
            if (expected_matches.size() == 0 && !in_valid && !cfg_valid)
                quiet_cycles = quiet_cycles + 1;
            else
                quiet_cycles = 0;
            in_taken  <= in_valid && in_ready;
            cfg_taken <= cfg_valid && cfg_ready;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Stimulus: a directed opening, then phases of random text under fresh patterns.
    initial
    begin
        logic [7:0]           alpha [3];
        int                   nsym;
        int                   plen;
        int                   eff;
        int                   n;
        int                   r;
        int                   first;
        logic [PAT_VEC_W-1:0] pv;
        logic [CFG_DATA_W-1:0] len_word;
        logic [CFG_INDEX_W-1:0] idx;

        rebuild_failure_links();

        // Empty pattern after reset: every boundary matches, the end one too.
        push_word(ACTION_TEXT, 8'h00);
        push_word(ACTION_TEXT, 8'hFF);
        push_word(ACTION_END, 8'hA5);

        // Pattern "aba": overlapping occurrences in "ababa".
        push_cfg(REG_PATTERN_LOW, 64'h0000_0000_0061_6261);
        push_cfg(REG_PATTERN_LENGTH, 64'd3);
        push_word(ACTION_TEXT, 8'h61);
        push_word(ACTION_TEXT, 8'h62);
        push_word(ACTION_TEXT, 8'h61);
        push_word(ACTION_TEXT, 8'h62);
        push_word(ACTION_TEXT, 8'h61);
        // A write to the unused index leaves the partial match in place.
        push_cfg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(ACTION_TEXT, 8'h62);
        push_word(ACTION_END, 8'h00);

        // An oversized length saturates to the full sixteen bytes of all ones.
        push_cfg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cfg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cfg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF4);
        for (int i = 0; i < 17; i++)
            push_word(ACTION_TEXT, 8'hFF);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: plen = PAT_BYTES;
                1: plen = 0;
                2: plen = $urandom_range(17, 31);
                3: plen = 1;
                default:
                    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                       : $urandom_range(1, 6);
            endcase
            eff  = (plen > PAT_BYTES) ? PAT_BYTES : plen;
            nsym = $urandom_range(1, 3);
            for (int i = 0; i < 3; i++)
                alpha[i] = 8'($urandom_range(0, 255));
            pv = {$urandom, $urandom, $urandom, $urandom};
            if (ph == 5)
            begin
                alpha[0] = 8'h00;
                alpha[1] = 8'hFF;
                nsym = 2;
            end
            else if (ph == 6)
            begin
                alpha[0] = 8'h00;
                alpha[1] = 8'h01;
                nsym = 2;
                pv = '0;
            end
            for (int i = 0; i < eff; i++)
                pv[i*8 +: 8] = alpha[$urandom_range(0, nsym - 1)];
            len_word = {$urandom, $urandom};
            len_word[LEN_CFG_W-1:0] = LEN_CFG_W'(plen);

            // All three registers, starting from a random one.
            first = $urandom_range(0, 2);
            for (int j = 0; j < 3; j++)
            begin
                idx = CFG_INDEX_W'((first + j) % 3);
                if (idx == REG_PATTERN_LENGTH)
                    push_cfg(idx, len_word);
                else if (idx == REG_PATTERN_LOW)
                    push_cfg(idx, pv[63:0]);
                else
                    push_cfg(idx, pv[127:64]);
            end
            if ($urandom_range(0, 3) == 0)
                push_cfg(REG_UNUSED, {$urandom, $urandom});

            // Mostly text over the pattern's own alphabet, with whole occurrences,
            // stray bytes and the odd end of text mixed in.
            n = 0;
            while (n < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    push_word(ACTION_END, 8'($urandom_range(0, 255)));
                    n++;
                end
                else if (r < 15 && eff > 0)
                begin
                    for (int i = 0; i < eff; i++)
                        push_word(ACTION_TEXT, pv[i*8 +: 8]);
                    n += eff;
                end
                else if (r < 25)
                begin
                    push_word(ACTION_TEXT, 8'($urandom_range(0, 255)));
                    n++;
                end
                else
                begin
                    push_word(ACTION_TEXT, alpha[$urandom_range(0, nsym - 1)]);
                    n++;
                end
            end
        end

        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || expected_matches.size() != 0 || in_valid || cfg_valid)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
